@@ rtl/pfsr_pkg.sv @@
// shared constants and types for the prime field square root block
package pfsr_pkg;

  localparam int DEFAULT_WIDTH = 64;

  // register reset values; modulus and root of unity at full 64-bit width
  localparam logic [63:0] MODULUS_RESET = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ROOT_UNITY_RESET = 64'd1;
  localparam logic [5:0]  ADICITY_RESET = 6'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_ROOT_UNITY = 2'd1;
  localparam logic [1:0] CFG_ADICITY = 2'd2;

  // request to the modular multiply unit
  typedef struct packed {
    logic start;
    logic reduce;   // reduce y modulo m instead of x*y
  } mm_req_t;

  // status back from the modular multiply unit
  typedef struct packed {
    logic busy;
    logic done;     // one-cycle pulse, result valid
  } mm_stat_t;

endpackage

@@ rtl/pfsr_modmul.sv @@
// bit-serial modular multiply and reduce unit built on one add/compare/subtract
module pfsr_modmul #(
  parameter int WIDTH = pfsr_pkg::DEFAULT_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  pfsr_pkg::mm_req_t  req,
  input  logic [WIDTH-1:0]   x,
  input  logic [WIDTH-1:0]   y,
  input  logic [WIDTH-1:0]   m,
  output pfsr_pkg::mm_stat_t stat,
  output logic [WIDTH-1:0]   result
);
  import pfsr_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [CW-1:0]    cnt;
  logic             phase;
  logic             busy;
  logic             done;
  logic             reduce;

  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] r_next;
  logic             cin;
  logic             last;

  // one modular add per cycle: r + (r or x) + carry-in, minus m when not below m
  always_comb begin
    cin    = reduce & ~phase & yr[WIDTH-1];
    sum    = {1'b0, r} + {1'b0, (phase ? xr : r)} + {{WIDTH{1'b0}}, cin};
    diff   = sum - {1'b0, m};
    r_next = (sum >= {1'b0, m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
    last   = (cnt == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (phase || reduce || !yr[WIDTH-1]) begin
          if (last) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      r      <= '0;
      xr     <= x;
      yr     <= y;
      cnt    <= CW'(WIDTH);
      phase  <= 1'b0;
      reduce <= req.reduce;
    end else if (busy) begin
      r <= r_next;
      if (!phase && !reduce && yr[WIDTH-1]) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        yr    <= yr << 1;
        cnt   <= cnt - CW'(1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = r;

endmodule

@@ rtl/prime_field_square_root.sv @@
// top level of the prime field square root block: sequencer and registers
// Square root in GF(p). One value transfer in gives one (root, is_square) transfer
// out; the block takes one item at a time and in_ready is low while it works.
// All arithmetic runs on a single bit-serial modular multiplier that does one
// modular add per cycle: a multiply doubles once per bit of its second operand
// and adds once more per set bit. Reducing the input and the root of unity runs
// the multiplier in reduce mode. For p = 3 mod 4 an item needs one exponentiation
// plus one multiply, roughly 1.5*WIDTH multiplies in all. Otherwise two
// exponentiations, three multiplies and about f*f/2 + 3f/2 further multiplies for
// the Tonelli-Shanks loop, f the two-adicity.
// Modulus below three returns root 0, is_square 0 in the cycle after the transfer;
// a value that reduces to zero returns root 0, is_square 1 after the reduction.
// Configuration writes are always taken (cfg_ready stays high) and must only
// come while the block is idle. Register indexes: 0 modulus, 1 root of unity,
// 2 two-adicity (low six bits); index 3 is ignored.
module prime_field_square_root #(
  parameter int WIDTH = pfsr_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] root,
  output logic             is_square,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [WIDTH-1:0] cfg_data
);
  import pfsr_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_RED_A = 14'b00000000000010,
    S_POW_Q = 14'b00000000000100,
    S_POW_M = 14'b00000000001000,
    S_CSQ   = 14'b00000000010000,
    S_RED_U = 14'b00000000100000,
    S_T1A   = 14'b00000001000000,
    S_T1B   = 14'b00000010000000,
    S_CA    = 14'b00000100000000,
    S_INNER = 14'b00001000000000,
    S_FIXC  = 14'b00010000000000,
    S_SQT3  = 14'b00100000000000,
    S_FIXT1 = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  // which exponentiation is running
  typedef enum logic [1:0] {
    POW_ROOT34 = 2'd0,   // value^((p+1)/4)
    POW_LEG    = 2'd1,   // legendre symbol
    POW_T0     = 2'd2    // value^(odd part of p-1, halved)
  } pow_id_t;

  state_t  state;
  pow_id_t pid;

  // configuration registers
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] root_of_unity;
  logic [5:0]       two_adicity;

  // working registers
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] pr;
  logic [WIDTH-1:0] pb;
  logic [WIDTH-1:0] pe;
  logic [CW-1:0]    pcnt;
  logic [WIDTH-1:0] c;
  logic [WIDTH-1:0] t1;
  logic [WIDTH-1:0] t2;
  logic [WIDTH-1:0] t3;
  logic [5:0]       j;
  logic [5:0]       icnt;
  logic             launched;

  // multiplier hookup
  mm_req_t          mreq;
  mm_stat_t         mstat;
  logic [WIDTH-1:0] mx;
  logic [WIDTH-1:0] my;
  logic [WIDTH-1:0] mres;
  logic             op_state;

  // helpers
  logic             fix;
  logic [WIDTH-1:0] t1_upd;
  logic [5:0]       j_next;
  logic [WIDTH-1:0] exp_34;
  logic [WIDTH-1:0] exp_leg;
  logic [WIDTH-1:0] exp_t0;
  logic [WIDTH-1:0] neg_c;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= MODULUS_RESET[WIDTH-1:0];
      root_of_unity <= ROOT_UNITY_RESET[WIDTH-1:0];
      two_adicity   <= ADICITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:    modulus <= cfg_data;
        CFG_ROOT_UNITY: root_of_unity <= cfg_data;
        CFG_ADICITY:    two_adicity <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op_state = !(state == S_IDLE || state == S_DONE);
    fix      = (t2 != WIDTH'(1));
    t1_upd   = fix ? mres : t1;
    j_next   = j - 6'd1;
    exp_34   = (modulus >> 2) + WIDTH'(1);
    exp_leg  = (modulus - WIDTH'(1)) >> 1;
    exp_t0   = (modulus >> two_adicity) >> 1;
    neg_c    = modulus - c;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mreq.start  = op_state && !launched;
    mreq.reduce = 1'b0;
    mx          = c;
    my          = c;
    unique case (state)
      S_RED_A: begin
        mreq.reduce = 1'b1;
        my          = a;
      end
      S_RED_U: begin
        mreq.reduce = 1'b1;
        my          = root_of_unity;
      end
      S_POW_Q: begin
        mx = pr;
        my = pr;
      end
      S_POW_M: begin
        mx = pr;
        my = pb;
      end
      S_T1A: begin
        mx = pr;
        my = pr;
      end
      S_T1B: begin
        mx = t1;
        my = a;
      end
      S_CA: begin
        mx = pr;
        my = a;
      end
      S_INNER: begin
        mx = t2;
        my = t2;
      end
      S_FIXC: begin
        mx = c;
        my = t3;
      end
      S_SQT3: begin
        mx = t3;
        my = t3;
      end
      S_FIXT1: begin
        mx = t1;
        my = t3;
      end
      default: ;
    endcase
  end

  pfsr_modmul #(
    .WIDTH(WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .x      (mx),
    .y      (my),
    .m      (modulus),
    .stat   (mstat),
    .result (mres)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      if (mreq.start) begin
        launched <= 1'b1;
      end
      if (mstat.done) begin
        launched <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (modulus < WIDTH'(3)) ? S_DONE : S_RED_A;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          if (mstat.done) begin
            unique case (state)
              S_RED_A: begin
                state <= (mres == '0) ? S_DONE : S_POW_Q;
              end
              S_POW_Q, S_POW_M: begin
                if (state == S_POW_Q && pe[WIDTH-1]) begin
                  state <= S_POW_M;
                end else if (pcnt != CW'(1)) begin
                  state <= S_POW_Q;
                end else begin
                  unique case (pid)
                    POW_ROOT34: state <= S_CSQ;
                    POW_LEG:    state <= S_POW_Q;
                    POW_T0:     state <= S_RED_U;
                    default:    state <= S_RED_U;
                  endcase
                end
              end
              S_CSQ:   state <= S_DONE;
              S_RED_U: state <= S_T1A;
              S_T1A:   state <= S_T1B;
              S_T1B:   state <= S_CA;
              S_CA: begin
                // loop count comes straight from the register, j loads at this edge
                if (two_adicity > 6'd1) begin
                  state <= (two_adicity == 6'd2) ? S_FIXC : S_INNER;
                end else begin
                  state <= S_DONE;
                end
              end
              S_INNER: state <= (icnt == 6'd1) ? S_FIXC : S_INNER;
              S_FIXC:  state <= S_SQT3;
              S_SQT3:  state <= S_FIXT1;
              S_FIXT1: begin
                if (j_next > 6'd1) begin
                  state <= (j_next == 6'd2) ? S_FIXC : S_INNER;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          a         <= value;
          root      <= '0;
          is_square <= 1'b0;
        end
      end
      default: begin
        if (mstat.done) begin
          unique case (state)
            S_RED_A: begin
              a <= mres;
              if (mres == '0) begin
                root      <= '0;
                is_square <= 1'b1;
              end else begin
                pr   <= WIDTH'(1);
                pb   <= mres;
                pcnt <= CW'(WIDTH);
                if (modulus[1:0] == 2'b11) begin
                  pe  <= exp_34;
                  pid <= POW_ROOT34;
                end else begin
                  pe  <= exp_leg;
                  pid <= POW_LEG;
                end
              end
            end
            S_POW_Q, S_POW_M: begin
              if (state == S_POW_Q && pe[WIDTH-1]) begin
                pr <= mres;
              end else if (pcnt != CW'(1)) begin
                pr   <= mres;
                pe   <= pe << 1;
                pcnt <= pcnt - CW'(1);
              end else begin
                unique case (pid)
                  POW_ROOT34: c <= mres;
                  POW_LEG: begin
                    // legendre done, start the odd-part power
                    is_square <= (mres == WIDTH'(1));
                    pr        <= WIDTH'(1);
                    pe        <= exp_t0;
                    pcnt      <= CW'(WIDTH);
                    pid       <= POW_T0;
                  end
                  default: pr <= mres;
                endcase
              end
            end
            S_CSQ: begin
              is_square <= (mres == a);
              root      <= c;
            end
            S_RED_U: t3 <= mres;
            S_T1A:   t1 <= mres;
            S_T1B:   t1 <= mres;
            S_CA: begin
              c    <= mres;
              j    <= two_adicity;
              t2   <= t1;
              icnt <= two_adicity - 6'd2;
              root <= mres[0] ? (modulus - mres) : mres;
            end
            S_INNER: begin
              t2   <= mres;
              icnt <= icnt - 6'd1;
            end
            S_FIXC: begin
              if (fix) begin
                c <= mres;
              end
            end
            S_SQT3: t3 <= mres;
            S_FIXT1: begin
              t1   <= t1_upd;
              t2   <= t1_upd;
              j    <= j_next;
              icnt <= j_next - 6'd2;
              root <= c[0] ? neg_c : c;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  // the multiplier is only started when it is free
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mstat.busy)
    else $error("multiplier started while busy");

  // a finished multiply always belongs to a launched operation
  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> launched && op_state)
    else $error("multiplier result with no pending operation");

  // no input is taken while a result is waiting
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a modulus below three gives root 0 and never reports a square
  a_small_mod: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && modulus < WIDTH'(3)) |=> out_valid && !is_square && root == '0)
    else $error("small modulus result wrong");

endmodule
